// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define PMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// Clocked assertion that is also checked during reset.
`define PMT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`endif

// ----- sv/pmt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

   localparam int POS_W    = 15;
   localparam int SCR_W    = 16;
   localparam int OUTL_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int PROD_W   = POS_W + SCR_W;
   // quotient never exceeds the span, so only SCR_W quotient bits are developed
   localparam int DIV_STEPS = SCR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTLIER_DX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTLIER_DY = 3'd5;

   // register reset values
   localparam logic [POS_W-1:0]  LIMIT_X_RST  = 15'd1000;
   localparam logic [POS_W-1:0]  LIMIT_Y_RST  = 15'd750;
   localparam logic [SCR_W-1:0]  SPAN_X_RST   = 16'd79;
   localparam logic [SCR_W-1:0]  SPAN_Y_RST   = 16'd24;
   localparam logic [OUTL_W-1:0] OUTLIER_RST  = 8'd150;

   // header bit positions
   localparam int HDR_ALWAYS_ONE = 3;
   localparam int HDR_SIGN_X     = 4;
   localparam int HDR_SIGN_Y     = 5;
   localparam int HDR_OVF_X      = 6;
   localparam int HDR_OVF_Y      = 7;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } seq_state_type;

   // status from the packet assembler to the sequencer
   typedef struct packed {
      logic       fire;      // complete packet accepted, positions updated
      logic [2:0] buttons;   // middle, right, left
   } pkt_stat_type;

endpackage

// ----- sv/ps2_mouse_packet_tracker_top.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// PS/2 mouse packet tracker: position and screen coordinate per packet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_pos_x/y, rsp_scr_x/y, buttons
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
//  Header and x-delta bytes are taken while the sequencer is idle. A third byte
//  that completes a good packet runs, per axis, a multiply/load state and 16
//  divider steps, both axes sharing one serial divider, then a done state.
//  A stalled result waits in the output register while new bytes are taken;
//  the next packet result waits in the done state until the old one leaves.
//  Synchronous active-high reset clears state and position and restores the
//  register defaults.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pmt_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pmt_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [pmt_pkg::POS_W-1:0]        rsp_pos_y,
   output logic [pmt_pkg::SCR_W-1:0]        rsp_scr_x,
   output logic [pmt_pkg::SCR_W-1:0]        rsp_scr_y,
   output logic                             rsp_button_left,
   output logic                             rsp_button_right,
   output logic                             rsp_button_middle,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pmt_pkg::CSR_DAT_W-1:0]    csr_data
);
   import pmt_pkg::*;

   logic [POS_W-1:0]  lim_x_ff, lim_y_ff;
   logic [SCR_W-1:0]  span_x_ff, span_y_ff;
   logic [OUTL_W-1:0] outl_x_ff, outl_y_ff;

   seq_state_type     state_ff, state_in;
   logic              axis_ff, axis_in;
   logic [SCR_W-1:0]  scr_x_ff, scr_x_in;
   logic [SCR_W-1:0]  scr_y_ff, scr_y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_rsp;

   logic [POS_W-1:0]  rsp_px_ff, rsp_py_ff;
   logic [SCR_W-1:0]  rsp_sx_ff, rsp_sy_ff;
   logic [2:0]        rsp_btn_ff;

   logic              req_accept;
   pkt_stat_type      pkt_stat;
   logic [POS_W-1:0]  pos_x, pos_y;
   logic [POS_W-1:0]  pos_sel, lim_sel;
   logic [SCR_W-1:0]  span_sel;
   logic [PROD_W-1:0] product;
   logic              div_start, div_done;
   logic [SCR_W-1:0]  quotient, scr_val;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_x_ff  <= LIMIT_X_RST;
         lim_y_ff  <= LIMIT_Y_RST;
         span_x_ff <= SPAN_X_RST;
         span_y_ff <= SPAN_Y_RST;
         outl_x_ff <= OUTLIER_RST;
         outl_y_ff <= OUTLIER_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LIMIT_X:    lim_x_ff  <= csr_data[POS_W-1:0];
            CSR_LIMIT_Y:    lim_y_ff  <= csr_data[POS_W-1:0];
            CSR_SPAN_X:     span_x_ff <= csr_data;
            CSR_SPAN_Y:     span_y_ff <= csr_data;
            CSR_OUTLIER_DX: outl_x_ff <= csr_data[OUTL_W-1:0];
            CSR_OUTLIER_DY: outl_y_ff <= csr_data[OUTL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   pmt_packet u_packet (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .rx_byte    (req_rx_byte),
      .limit_x    (lim_x_ff),
      .limit_y    (lim_y_ff),
      .outlier_dx (outl_x_ff),
      .outlier_dy (outl_y_ff),
      .stat       (pkt_stat),
      .pos_x      (pos_x),
      .pos_y      (pos_y)
   );

   assign pos_sel   = axis_ff ? pos_y : pos_x;
   assign lim_sel   = axis_ff ? lim_y_ff : lim_x_ff;
   assign span_sel  = axis_ff ? span_y_ff : span_x_ff;
   assign product   = PROD_W'(pos_sel) * PROD_W'(span_sel);
   assign div_start = (state_ff == ST_LOAD);
   // a zero limit maps the axis to column zero
   assign scr_val   = (lim_sel == '0) ? '0 : quotient;

   pmt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (lim_sel),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      scr_x_in = scr_x_ff;
      scr_y_in = scr_y_ff;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pkt_stat.fire) begin
               axis_in  = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (axis_ff) begin
                  scr_y_in = scr_val;
                  state_in = ST_DONE;
               end else begin
                  scr_x_in = scr_val;
                  axis_in  = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scr_x_ff <= scr_x_in;
      scr_y_ff <= scr_y_in;
      if (load_rsp) begin
         rsp_px_ff  <= pos_x;
         rsp_py_ff  <= pos_y;
         rsp_sx_ff  <= scr_x_ff;
         rsp_sy_ff  <= scr_y_ff;
         rsp_btn_ff <= pkt_stat.buttons;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_px_ff;
   assign rsp_pos_y         = rsp_py_ff;
   assign rsp_scr_x         = rsp_sx_ff;
   assign rsp_scr_y         = rsp_sy_ff;
   assign rsp_button_left   = rsp_btn_ff[0];
   assign rsp_button_right  = rsp_btn_ff[1];
   assign rsp_button_middle = rsp_btn_ff[2];

endmodule

// ----- sv/pmt_divider.sv -----
// ----------------------------------------------------------------------------
// pmt_divider
// Restoring divider, one quotient bit per cycle, 16 steps.
// ----------------------------------------------------------------------------
module pmt_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pmt_pkg::PROD_W-1:0]   dividend,
   input  logic [pmt_pkg::POS_W-1:0]    divisor,
   output logic                         done,
   output logic [pmt_pkg::SCR_W-1:0]    quotient
);
   import pmt_pkg::*;

   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [SCR_W-1:0]     quo_ff, quo_in;
   logic [POS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [POS_W:0]       trial;
   logic [POS_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[SCR_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // upper bits are already below the divisor since the quotient fits SCR_W
         rem_in = dividend[PROD_W-1:SCR_W];
         quo_in = dividend[SCR_W-1:0];
         dvs_in = divisor;
         cnt_in = DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
         quo_in  = {quo_ff[SCR_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/pmt_packet.sv -----
// ----------------------------------------------------------------------------
// pmt_packet
// Assembles 3-byte packets, filters them and moves the clamped position.
// ----------------------------------------------------------------------------
module pmt_packet (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pmt_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [pmt_pkg::POS_W-1:0]     limit_x,
   input  logic [pmt_pkg::POS_W-1:0]     limit_y,
   input  logic [pmt_pkg::OUTL_W-1:0]    outlier_dx,
   input  logic [pmt_pkg::OUTL_W-1:0]    outlier_dy,
   output pmt_pkg::pkt_stat_type         stat,
   output logic [pmt_pkg::POS_W-1:0]     pos_x,
   output logic [pmt_pkg::POS_W-1:0]     pos_y
);
   import pmt_pkg::*;

   logic [1:0]        cnt_ff, cnt_in;
   logic [BYTE_W-1:0] hdr_ff, hdr_in;
   logic [BYTE_W-1:0] xb_ff, xb_in;
   logic [POS_W-1:0]  px_ff, px_in;
   logic [POS_W-1:0]  py_ff, py_in;

   logic signed [9:0] dx, dy;
   logic [9:0]        mag_x, mag_y;
   logic              ovf, outlier, fire;
   logic [POS_W-1:0]  new_x, new_y;

   function automatic logic [POS_W-1:0] move_axis(input logic [POS_W-1:0] pos,
                                                  input logic signed [9:0] d,
                                                  input logic [POS_W-1:0] lim);
      logic signed [POS_W+1:0] s;
      s = $signed({2'b00, pos}) + {{(POS_W-8){d[9]}}, d};
      if (s[POS_W+1])
         return '0;
      else if (s[POS_W:0] > {1'b0, lim})
         return lim;
      else
         return s[POS_W-1:0];
   endfunction

   assign dx    = $signed({hdr_ff[HDR_SIGN_X], hdr_ff[HDR_SIGN_X], xb_ff});
   assign dy    = -$signed({hdr_ff[HDR_SIGN_Y], hdr_ff[HDR_SIGN_Y], rx_byte});
   assign mag_x = dx[9] ? 10'(-dx) : 10'(dx);
   assign mag_y = dy[9] ? 10'(-dy) : 10'(dy);
   assign ovf     = hdr_ff[HDR_OVF_X] | hdr_ff[HDR_OVF_Y];
   assign outlier = (mag_x > {2'b00, outlier_dx}) | (mag_y > {2'b00, outlier_dy});
   assign fire    = accept && (cnt_ff == 2'd2) && !ovf && !outlier;
   assign new_x   = move_axis(px_ff, dx, limit_x);
   assign new_y   = move_axis(py_ff, dy, limit_y);

   always_comb begin
      cnt_in = cnt_ff;
      hdr_in = hdr_ff;
      xb_in  = xb_ff;
      px_in  = px_ff;
      py_in  = py_ff;
      if (accept) begin
         case (cnt_ff)
            2'd0: begin
               // resync: wait for a byte with the always-one flag
               if (rx_byte[HDR_ALWAYS_ONE]) begin
                  hdr_in = rx_byte;
                  cnt_in = 2'd1;
               end
            end
            2'd1: begin
               xb_in  = rx_byte;
               cnt_in = 2'd2;
            end
            default: begin
               cnt_in = 2'd0;
               if (fire) begin
                  px_in = new_x;
                  py_in = new_y;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         hdr_ff <= '0;
         xb_ff  <= '0;
         px_ff  <= '0;
         py_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         hdr_ff <= hdr_in;
         xb_ff  <= xb_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
      end
   end

   assign stat.fire    = fire;
   assign stat.buttons = hdr_ff[2:0];
   assign pos_x        = px_ff;
   assign pos_y        = py_ff;

endmodule

// ----- sv/pmt_checker.sv -----
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks on the packet tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pmt_pkg::POS_W-1:0]        rsp_pos_x,
   input logic [pmt_pkg::POS_W-1:0]        rsp_pos_y,
   input logic [pmt_pkg::SCR_W-1:0]        rsp_scr_x,
   input logic [pmt_pkg::SCR_W-1:0]        rsp_scr_y,
   input logic                             rsp_button_left,
   input logic                             rsp_button_right,
   input logic                             rsp_button_middle,
   input logic                             csr_valid,
   input logic                             csr_ready
);
   import pmt_pkg::*;

   logic [2*POS_W+2*SCR_W+2:0] rsp_pld;

   assign rsp_pld = {rsp_pos_x, rsp_pos_y, rsp_scr_x, rsp_scr_y,
                     rsp_button_left, rsp_button_right, rsp_button_middle};

   // reset empties the output register
   `PMT_ASSERT_ALWAYS(a_rst_clears_rsp, clock, reset |=> !rsp_valid)

   // a stalled transaction keeps valid and payload
   `PMT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pld))

   // a new result only follows a busy cycle of the sequencer
   `PMT_ASSERT(a_rsp_after_busy, clock, reset, $rose(rsp_valid) |-> !$past(req_ready))

   // register writes are never back-pressured
   `PMT_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready)

endmodule

bind ps2_mouse_packet_tracker_top pmt_checker u_pmt_checker (.*);

// ----- test/tb_ps2_mouse_packet_tracker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker_top
// Self-checking bench for the PS/2 mouse packet tracker. Mouse bytes (framed
// packets, overflow and outlier packets, stray and truncated bytes) are
// streamed in under several register settings. A tracker model in the bench
// predicts each cursor report, and reports are checked field by field.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker_top;
   import pmt_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [SCR_W-1:0] scr_x;
      logic [SCR_W-1:0] scr_y;
      logic             left;
      logic             right;
      logic             middle;
   } cursor_rpt_type;

   class cursor_scoreboard_type;
      logic [POS_W-1:0]  lim_x, lim_y;
      logic [SCR_W-1:0]  span_x, span_y;
      logic [OUTL_W-1:0] max_dx, max_dy;
      logic [1:0]        byte_cnt;
      logic [BYTE_W-1:0] hdr_byte, dx_byte;
      logic [POS_W-1:0]  cur_x, cur_y;
      cursor_rpt_type    cursor_due[$];
      int errors, bytes_used, packets, dropped, matched;

      function new();
         lim_x    = LIMIT_X_RST;
         lim_y    = LIMIT_Y_RST;
         span_x   = SPAN_X_RST;
         span_y   = SPAN_Y_RST;
         max_dx   = OUTLIER_RST;
         max_dy   = OUTLIER_RST;
         byte_cnt = '0;
         hdr_byte = '0;
         dx_byte  = '0;
         cur_x    = '0;
         cur_y    = '0;
         errors     = 0;
         bytes_used = 0;
         packets    = 0;
         dropped    = 0;
         matched    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] d);
         case (idx)
            CSR_LIMIT_X:    lim_x  = d[POS_W-1:0];
            CSR_LIMIT_Y:    lim_y  = d[POS_W-1:0];
            CSR_SPAN_X:     span_x = d;
            CSR_SPAN_Y:     span_y = d;
            CSR_OUTLIER_DX: max_dx = d[OUTL_W-1:0];
            CSR_OUTLIER_DY: max_dy = d[OUTL_W-1:0];
            default: ;
         endcase
      endfunction

      function int delta9(logic sign, logic [BYTE_W-1:0] low);
         int v;
         v = int'(low);
         if (sign) v = v - 256;
         return v;
      endfunction

      function logic [POS_W-1:0] step_axis(logic [POS_W-1:0] p, int d,
                                            logic [POS_W-1:0] lim);
         int s, top;
         s   = int'(p);
         top = int'(lim);
         s   = s + d;
         if (s < 0) return '0;
         if (s > top) return lim;
         return s[POS_W-1:0];
      endfunction

      function logic [SCR_W-1:0] to_screen(logic [POS_W-1:0] p, logic [SCR_W-1:0] span,
                                            logic [POS_W-1:0] lim);
         logic [63:0] prod;
         if (lim == '0) return '0;
         prod = 64'(p);
         prod = prod * span;
         prod = prod / lim;
         return prod[SCR_W-1:0];
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         int dx, dy, adx, ady, top_dx, top_dy;
         cursor_rpt_type rpt;
         if (byte_cnt == 2'd0) begin
            // no always-one flag: stray byte, framing stays at the header
            if (b[HDR_ALWAYS_ONE]) begin
               hdr_byte   = b;
               byte_cnt   = 2'd1;
               bytes_used = bytes_used + 1;
            end
            return;
         end
         bytes_used = bytes_used + 1;
         if (byte_cnt == 2'd1) begin
            dx_byte  = b;
            byte_cnt = 2'd2;
            return;
         end
         byte_cnt = 2'd0;
         packets  = packets + 1;
         dx  = delta9(hdr_byte[HDR_SIGN_X], dx_byte);
         dy  = -delta9(hdr_byte[HDR_SIGN_Y], b);
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         top_dx = int'(max_dx);
         top_dy = int'(max_dy);
         if (hdr_byte[HDR_OVF_X] || hdr_byte[HDR_OVF_Y] || adx > top_dx || ady > top_dy)
         begin
            dropped = dropped + 1;
            return;
         end
         cur_x = step_axis(cur_x, dx, lim_x);
         cur_y = step_axis(cur_y, dy, lim_y);
         rpt.pos_x  = cur_x;
         rpt.pos_y  = cur_y;
         rpt.scr_x  = to_screen(cur_x, span_x, lim_x);
         rpt.scr_y  = to_screen(cur_y, span_y, lim_y);
         rpt.left   = hdr_byte[0];
         rpt.right  = hdr_byte[1];
         rpt.middle = hdr_byte[2];
         cursor_due.push_back(rpt);
      endfunction

      task report(string what, int got, int want);
         errors = errors + 1;
         if (errors <= 40)
            $display("mismatch %s: got %0d, expected %0d (report %0d)",
                     what, got, want, matched);
      endtask

      task check_cursor(cursor_rpt_type got);
         cursor_rpt_type want;
         if (cursor_due.size() == 0) begin
            report("cursor report with none pending, pos_x", int'(got.pos_x), -1);
            return;
         end
         want = cursor_due.pop_front();
         if (got.pos_x !== want.pos_x)
            report("pos_x", int'(got.pos_x), int'(want.pos_x));
         if (got.pos_y !== want.pos_y)
            report("pos_y", int'(got.pos_y), int'(want.pos_y));
         if (got.scr_x !== want.scr_x)
            report("scr_x", int'(got.scr_x), int'(want.scr_x));
         if (got.scr_y !== want.scr_y)
            report("scr_y", int'(got.scr_y), int'(want.scr_y));
         if (got.left !== want.left)
            report("button_left", int'(got.left), int'(want.left));
         if (got.right !== want.right)
            report("button_right", int'(got.right), int'(want.right));
         if (got.middle !== want.middle)
            report("button_middle", int'(got.middle), int'(want.middle));
         matched = matched + 1;
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [POS_W-1:0]     rsp_pos_x;
   logic [POS_W-1:0]     rsp_pos_y;
   logic [SCR_W-1:0]     rsp_scr_x;
   logic [SCR_W-1:0]     rsp_scr_y;
   logic                 rsp_button_left;
   logic                 rsp_button_right;
   logic                 rsp_button_middle;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   cursor_scoreboard_type sb;
   logic steady;        // no idling on either side while set
   int   cycle_count = 0;
   int   settings    = 0;

   ps2_mouse_packet_tracker_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_scr_x         (rsp_scr_x),
      .rsp_scr_y         (rsp_scr_y),
      .rsp_button_left   (rsp_button_left),
      .rsp_button_right  (rsp_button_right),
      .rsp_button_middle (rsp_button_middle),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL ps2_mouse_packet_tracker_top");
      $finish;
   end

   // transaction monitor
   always @(posedge clock) begin : watch
      cursor_rpt_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pos_x, rsp_pos_y, rsp_scr_x, rsp_scr_y,
                    rsp_button_left, rsp_button_right, rsp_button_middle};
            sb.check_cursor(got);
         end
         if (req_valid && req_ready) sb.note_byte(req_rx_byte);
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && (steady || $urandom_range(99) >= 30);

   // entered and left at a falling edge; valid stays up after the transaction
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // raw_y is the wire value: the tracker treats its negation as upward motion
   task automatic send_packet(input logic [2:0] btn, input int raw_x, input int raw_y,
                              input logic [1:0] ovf);
      logic [8:0]        rx9, ry9;
      logic [BYTE_W-1:0] hdr;
      rx9 = raw_x[8:0];
      ry9 = raw_y[8:0];
      hdr = {ovf[1], ovf[0], ry9[8], rx9[8], 1'b1, btn};
      send_byte(hdr);
      send_byte(rx9[7:0]);
      send_byte(ry9[7:0]);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DAT_W-1:0] lx, input logic [CSR_DAT_W-1:0] ly,
                                input logic [CSR_DAT_W-1:0] sx, input logic [CSR_DAT_W-1:0] sy,
                                input logic [CSR_DAT_W-1:0] ox, input logic [CSR_DAT_W-1:0] oy);
      csr_write(CSR_LIMIT_X, lx);
      csr_write(CSR_LIMIT_Y, ly);
      csr_write(CSR_SPAN_X, sx);
      csr_write(CSR_SPAN_Y, sy);
      csr_write(CSR_OUTLIER_DX, ox);
      csr_write(CSR_OUTLIER_DY, oy);
      settings = settings + 1;
   endtask

   task automatic random_setting();
      logic [CSR_DAT_W-1:0] lx, ly, sx, sy, ox, oy;
      lx = CSR_DAT_W'($urandom);
      ly = CSR_DAT_W'($urandom);
      sx = CSR_DAT_W'($urandom);
      sy = CSR_DAT_W'($urandom);
      ox = CSR_DAT_W'($urandom);
      oy = CSR_DAT_W'($urandom);
      if ($urandom_range(3) == 0) lx[POS_W-1:0] = POS_W'($urandom_range(1, 20));
      if ($urandom_range(3) == 0) ly[POS_W-1:0] = POS_W'($urandom_range(1, 20));
      if ($urandom_range(1) == 0) ox[OUTL_W-1:0] = OUTL_W'($urandom_range(100, 255));
      if ($urandom_range(1) == 0) oy[OUTL_W-1:0] = OUTL_W'($urandom_range(100, 255));
      apply_setting(lx, ly, sx, sy, ox, oy);
   endtask

   // mostly in range, some right at the outlier bound, some anywhere in 9 bits
   function automatic int pick_delta(input int lim);
      int r;
      r = $urandom_range(99);
      if (r < 55) return int'($urandom_range(0, 2 * lim)) - lim;
      if (r < 70) return ($urandom_range(1) ? 1 : -1) * (lim + int'($urandom_range(1)));
      return int'($urandom_range(0, 511)) - 256;
   endfunction

   task automatic random_traffic(input int budget);
      int          stop_at, r;
      logic [1:0]  ovf;
      stop_at = sb.bytes_used + budget;
      while (sb.bytes_used < stop_at) begin
         r = $urandom_range(99);
         if (r < 85) begin
            // realign on a packet boundary before a framed packet
            while (sb.byte_cnt != 2'd0) send_byte(BYTE_W'($urandom_range(255)));
            ovf[0] = $urandom_range(99) < 6;
            ovf[1] = $urandom_range(99) < 6;
            send_packet(3'($urandom_range(7)), pick_delta(int'(sb.max_dx)),
                        pick_delta(int'(sb.max_dy)), ovf);
         end else if (r < 95) begin
            send_byte(BYTE_W'($urandom_range(255)));
         end else begin
            // header and one delta byte only
            send_byte(BYTE_W'($urandom_range(255) | (1 << HDR_ALWAYS_ONE)));
            send_byte(BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   // wait for every outstanding report, then let the divider go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.cursor_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      sb          = new();
      steady      = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset register values
      send_byte(8'h00);
      send_byte(8'hF7);
      send_packet(3'b000, 0, 0, 2'b00);
      send_packet(3'b001, 150, -150, 2'b00);
      send_byte(8'hFF);
      send_byte(8'h12);
      send_byte(8'h34);
      send_packet(3'b010, 5, 5, 2'b01);
      send_packet(3'b100, 5, 5, 2'b10);
      send_packet(3'b111, -151, 0, 2'b00);
      send_packet(3'b011, 0, 151, 2'b00);
      send_packet(3'b111, -150, -150, 2'b00);
      random_traffic(180);
      drain();

      // widest ranges, register data with unused upper bits set
      apply_setting(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
      steady = 1'b1;
      repeat (130) send_packet(3'($urandom_range(7)), 255, -255, 2'b00);
      random_traffic(100);
      steady = 1'b0;
      drain();

      // limits dropped far below the current position, x moves refused
      apply_setting(16'd1, 16'd3, 16'd0, 16'd7, 16'd0, 16'd255);
      send_packet(3'b000, 0, 0, 2'b00);
      random_traffic(200);
      drain();

      // zero limits (bit 15 is not stored)
      apply_setting(16'h8000, 16'h8000, 16'hFFFF, 16'h1234, 16'd200, 16'd200);
      random_traffic(100);
      drain();

      for (int i = CSR_OUTLIER_DY + 1; i < 2 ** CSR_IDX_W; i++)
         csr_write(i[CSR_IDX_W-1:0], CSR_DAT_W'($urandom));
      repeat (3) begin
         random_setting();
         random_traffic(100);
         drain();
      end

      if (sb.cursor_due.size() != 0)
         sb.report("cursor reports never delivered", 0, sb.cursor_due.size());
      $display("run: %0d bytes framed, %0d packets completed, %0d dropped as overflow/outlier",
               sb.bytes_used, sb.packets, sb.dropped);
      $display("run: %0d cursor reports checked over %0d register settings, %0d mismatches",
               sb.matched, settings, sb.errors);
      if (sb.errors == 0)
         $display("PASS ps2_mouse_packet_tracker_top");
      else
         $display("FAIL ps2_mouse_packet_tracker_top");
      $finish;
   end

endmodule
